[rtl/pvdq_pkg.sv]
// Shared types, constants and field helpers for the packed vector dequantizer.
// No dependencies; used by pvdq_lane, pvdq_merge and packed_vector_dequantizer.
`default_nettype none

package pvdq_pkg;

    // Packed code formats (register format_mode)
    typedef enum logic [1:0] {
        FMT_5BIT  = 2'd0,
        FMT_10BIT = 2'd1,
        FMT_21BIT = 2'd2,
        FMT_16BIT = 2'd3
    } fmt_t;

    // Component select codes (register component_select)
    localparam logic [1:0] COMP_X   = 2'd0;
    localparam logic [1:0] COMP_Y   = 2'd1;
    localparam logic [1:0] COMP_Z   = 2'd2;
    localparam logic [1:0] COMP_ALL = 2'd3;

    // Register indexes
    localparam logic [2:0] REG_FORMAT_MODE = 3'd0;
    localparam logic [2:0] REG_COMPONENT   = 3'd1;
    localparam logic [2:0] REG_SCALE_X     = 3'd2;
    localparam logic [2:0] REG_SCALE_Y     = 3'd3;
    localparam logic [2:0] REG_SCALE_Z     = 3'd4;
    localparam logic [2:0] REG_OFFSET_X    = 3'd5;
    localparam logic [2:0] REG_OFFSET_Y    = 3'd6;
    localparam logic [2:0] REG_OFFSET_Z    = 3'd7;

    localparam int CODE_W   = 63;
    localparam int DATA_W   = 32;
    localparam int FIELD_W  = 21;
    localparam int SHIFT_W  = 5;
    localparam int PROD_W   = FIELD_W + DATA_W;
    localparam int ADDR_W   = 5;

    // Reduction steps x = H*2^b + L  ->  q += H, x = H + L
    localparam int RED_STAGES  = 10;
    // multiply stage + reduction stages + final correction/offset stage
    localparam int LANE_STAGES = RED_STAGES + 2;
    // lane stages + output register
    localparam int PIPE_DEPTH  = LANE_STAGES + 1;

    localparam logic [FIELD_W-1:0] MAX_5BIT  = 21'h1f;
    localparam logic [FIELD_W-1:0] MAX_10BIT = 21'h3ff;
    localparam logic [FIELD_W-1:0] MAX_21BIT = 21'h1fffff;
    localparam logic [FIELD_W-1:0] MAX_16BIT = 21'h00ffff;

    typedef logic [DATA_W-1:0] word_t;

    function automatic logic [SHIFT_W-1:0] fmt_bits(input fmt_t fmt);
        logic [SHIFT_W-1:0] b;
        case (fmt)
            FMT_5BIT:  b = 5'd5;
            FMT_10BIT: b = 5'd10;
            FMT_21BIT: b = 5'd21;
            FMT_16BIT: b = 5'd16;
            default:   b = 5'd5;
        endcase
        return b;
    endfunction

    function automatic logic [FIELD_W-1:0] fmt_max(input fmt_t fmt);
        logic [FIELD_W-1:0] m;
        case (fmt)
            FMT_5BIT:  m = MAX_5BIT;
            FMT_10BIT: m = MAX_10BIT;
            FMT_21BIT: m = MAX_21BIT;
            FMT_16BIT: m = MAX_16BIT;
            default:   m = MAX_5BIT;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

[rtl/pvdq_lane.sv]
// One dequantization lane: |field*scale|, division by 2^b-1 by end-around
// reduction steps, sign restore and offset add. Depends on pvdq_pkg.
`default_nettype none

module pvdq_lane (
    input  wire logic                                    clk,
    input  wire logic [pvdq_pkg::LANE_STAGES-1:0]        en,
    input  wire pvdq_pkg::fmt_t                          fmt,
    input  wire logic [pvdq_pkg::FIELD_W-1:0]            field,
    input  wire pvdq_pkg::word_t                         scale,
    input  wire pvdq_pkg::word_t                         offset,
    output pvdq_pkg::word_t                              result
);

    localparam int PW = pvdq_pkg::PROD_W;
    localparam int RS = pvdq_pkg::RED_STAGES;

    logic [PW-1:0]                  x_reg [0:RS];
    logic [pvdq_pkg::DATA_W-1:0]    q_reg [0:RS];
    pvdq_pkg::word_t                res_reg;

    logic [pvdq_pkg::DATA_W-1:0]    scale_mag;
    logic [PW-1:0]                  x0_next;
    logic [pvdq_pkg::SHIFT_W-1:0]   shamt;
    logic [PW-1:0]                  low_mask;
    logic [pvdq_pkg::DATA_W-1:0]    qsum;
    logic [pvdq_pkg::DATA_W-1:0]    qsigned;
    pvdq_pkg::word_t                res_next;

    // Magnitude of the signed scale; -2^31 maps to 2^31, which still fits
    assign scale_mag = scale[pvdq_pkg::DATA_W-1] ? (~scale + 1'b1) : scale;
    assign x0_next   = PW'(field) * PW'(scale_mag);
    assign shamt     = pvdq_pkg::fmt_bits(fmt);
    assign low_mask  = PW'(pvdq_pkg::fmt_max(fmt));

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x_reg[0] <= x0_next;
            q_reg[0] <= '0;
        end
    end

    // Since 2^b = M + 1: x = H*M + (H + L), so q(x) = H + q(H + L)
    for (genvar k = 1; k <= RS; k++) begin : g_red
        logic [PW-1:0]               hi;
        logic [PW-1:0]               x_next;
        logic [pvdq_pkg::DATA_W-1:0] q_next;

        assign hi     = x_reg[k-1] >> shamt;
        assign x_next = hi + (x_reg[k-1] & low_mask);
        assign q_next = q_reg[k-1] + hi[pvdq_pkg::DATA_W-1:0];

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                x_reg[k] <= x_next;
                q_reg[k] <= q_next;
            end
        end
    end

    // Remainder is now below 2^b; it equals M in exactly one case
    always_comb
    begin
        qsum     = q_reg[RS] + ((x_reg[RS] >= low_mask) ? 32'd1 : 32'd0);
        qsigned  = scale[pvdq_pkg::DATA_W-1] ? (~qsum + 1'b1) : qsum;
        res_next = offset + qsigned;
    end

    always_ff @(posedge clk)
    begin
        if (en[RS+1])
        begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

endmodule

`default_nettype wire

[rtl/pvdq_merge.sv]
// Merge stage: combine the lane results into the output vector and hold it
// in the output register. Depends on pvdq_pkg.
`default_nettype none

module pvdq_merge (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire pvdq_pkg::fmt_t    fmt,
    input  wire logic [1:0]        comp,
    input  wire pvdq_pkg::word_t   lane_x,
    input  wire pvdq_pkg::word_t   lane_y,
    input  wire pvdq_pkg::word_t   lane_z,
    input  wire pvdq_pkg::word_t   offset_x,
    input  wire pvdq_pkg::word_t   offset_y,
    input  wire pvdq_pkg::word_t   offset_z,
    output pvdq_pkg::word_t        out_x,
    output pvdq_pkg::word_t        out_y,
    output pvdq_pkg::word_t        out_z,
    output pvdq_pkg::word_t        out_w
);

    pvdq_pkg::word_t x_reg, y_reg, z_reg, w_reg;
    pvdq_pkg::word_t x_next, y_next, z_next, w_next;

    always_comb
    begin
        x_next = lane_x;
        y_next = lane_y;
        z_next = lane_z;
        w_next = '0;
        if (fmt == pvdq_pkg::FMT_16BIT)
        begin
            x_next = offset_x;
            y_next = offset_y;
            z_next = offset_z;
            case (comp)
                pvdq_pkg::COMP_X:   x_next = lane_x;
                pvdq_pkg::COMP_Y:   y_next = lane_x;
                pvdq_pkg::COMP_Z:   z_next = lane_x;
                pvdq_pkg::COMP_ALL:
                begin
                    x_next = lane_x;
                    y_next = lane_x;
                    z_next = lane_x;
                    w_next = lane_x;
                end
                default: x_next = lane_x;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
            w_reg <= w_next;
        end
    end

    assign out_x = x_reg;
    assign out_y = y_reg;
    assign out_z = z_reg;
    assign out_w = w_reg;

endmodule

`default_nettype wire

[rtl/packed_vector_dequantizer.sv]
// Packed vector dequantizer: three dequantization lanes side by side, then
// a merge stage. Usage:
//   Input channel in_valid/in_stall carries one 63-bit packed_code per beat.
//   Output channel out_valid/out_stall carries out_x/out_y/out_z/out_w.
//   A beat moves at a clock edge with valid high and stall low.
//   The APB port writes and reads the eight setup registers at 4*index;
//   write them only while no beat is in flight.
// Pipeline: 13 register stages; a result is presented once its input beat
//   has passed through them in order (multiply, 10 reduction steps, offset
//   add, output register).
// Throughput: one beat per cycle while the output is not stalled, set by the
//   fully pipelined lanes; the final lane stage chains three adds.
// Reset: rst_n clears all valid flags and returns the setup registers to their
//   reset values (unit scale, zero offset, 5-bit format).
// Stall: a stalled output holds its beat; stages behind it keep moving until
//   they fill, and only then is in_stall raised.
`default_nettype none

module packed_vector_dequantizer #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // input channel
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [pvdq_pkg::CODE_W-1:0]       packed_code,
    // output channel
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [pvdq_pkg::DATA_W-1:0]     out_x,
    output logic signed [pvdq_pkg::DATA_W-1:0]     out_y,
    output logic signed [pvdq_pkg::DATA_W-1:0]     out_z,
    output logic signed [pvdq_pkg::DATA_W-1:0]     out_w,
    // APB setup port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [pvdq_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [pvdq_pkg::DATA_W-1:0]       pwdata,
    output logic [pvdq_pkg::DATA_W-1:0]            prdata,
    output logic                                   pready
);

    localparam int DEPTH = pvdq_pkg::PIPE_DEPTH;
    localparam int LS    = pvdq_pkg::LANE_STAGES;
    localparam int FW    = pvdq_pkg::FIELD_W;
    localparam pvdq_pkg::word_t SCALE_ONE = pvdq_pkg::word_t'(64'd1 << FRAC_BITS);

    // ------------------------------------------------------------------
    // Setup registers
    // ------------------------------------------------------------------
    pvdq_pkg::fmt_t  fmt_reg;
    logic [1:0]      comp_reg;
    pvdq_pkg::word_t scale_x_reg, scale_y_reg, scale_z_reg;
    pvdq_pkg::word_t offset_x_reg, offset_y_reg, offset_z_reg;

    logic            cfg_wr;
    logic [2:0]      cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg      <= pvdq_pkg::FMT_5BIT;
            comp_reg     <= pvdq_pkg::COMP_X;
            scale_x_reg  <= SCALE_ONE;
            scale_y_reg  <= SCALE_ONE;
            scale_z_reg  <= SCALE_ONE;
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            offset_z_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                pvdq_pkg::REG_FORMAT_MODE: fmt_reg      <= pvdq_pkg::fmt_t'(pwdata[1:0]);
                pvdq_pkg::REG_COMPONENT:   comp_reg     <= pwdata[1:0];
                pvdq_pkg::REG_SCALE_X:     scale_x_reg  <= pwdata;
                pvdq_pkg::REG_SCALE_Y:     scale_y_reg  <= pwdata;
                pvdq_pkg::REG_SCALE_Z:     scale_z_reg  <= pwdata;
                pvdq_pkg::REG_OFFSET_X:    offset_x_reg <= pwdata;
                pvdq_pkg::REG_OFFSET_Y:    offset_y_reg <= pwdata;
                pvdq_pkg::REG_OFFSET_Z:    offset_z_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (cfg_idx)
            pvdq_pkg::REG_FORMAT_MODE: prdata = {30'b0, fmt_reg};
            pvdq_pkg::REG_COMPONENT:   prdata = {30'b0, comp_reg};
            pvdq_pkg::REG_SCALE_X:     prdata = scale_x_reg;
            pvdq_pkg::REG_SCALE_Y:     prdata = scale_y_reg;
            pvdq_pkg::REG_SCALE_Z:     prdata = scale_z_reg;
            pvdq_pkg::REG_OFFSET_X:    prdata = offset_x_reg;
            pvdq_pkg::REG_OFFSET_Y:    prdata = offset_y_reg;
            pvdq_pkg::REG_OFFSET_Z:    prdata = offset_z_reg;
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline occupancy: a stage loads when it is empty or its occupant
    // moves on, so bubbles close up behind a stalled output.
    // ------------------------------------------------------------------
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic [DEPTH-1:0] load;

    always_comb
    begin
        load[DEPTH-1] = !valid_reg[DEPTH-1] || !out_stall;
        for (int i = DEPTH - 2; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (load[i])
            begin
                valid_next[i] = (i == 0) ? in_valid : valid_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = !load[0];
    assign out_valid = valid_reg[DEPTH-1];

    // ------------------------------------------------------------------
    // Field extraction per format; in the single-component format lane x
    // carries the 16-bit code against scale_x and the selected offset.
    // ------------------------------------------------------------------
    logic [FW-1:0]   fld_x, fld_y, fld_z;
    pvdq_pkg::word_t lane_off_x;

    always_comb
    begin
        case (fmt_reg)
            pvdq_pkg::FMT_5BIT:
            begin
                fld_x = FW'(packed_code[4:0]);
                fld_y = FW'(packed_code[9:5]);
                fld_z = FW'(packed_code[14:10]);
            end
            pvdq_pkg::FMT_10BIT:
            begin
                fld_x = FW'(packed_code[9:0]);
                fld_y = FW'(packed_code[19:10]);
                fld_z = FW'(packed_code[29:20]);
            end
            pvdq_pkg::FMT_21BIT:
            begin
                fld_x = packed_code[20:0];
                fld_y = packed_code[41:21];
                fld_z = packed_code[62:42];
            end
            pvdq_pkg::FMT_16BIT:
            begin
                fld_x = FW'(packed_code[15:0]);
                fld_y = '0;
                fld_z = '0;
            end
            default:
            begin
                fld_x = '0;
                fld_y = '0;
                fld_z = '0;
            end
        endcase
    end

    // Broadcast picks offset_x (component index 3 mod 3)
    always_comb
    begin
        lane_off_x = offset_x_reg;
        if (fmt_reg == pvdq_pkg::FMT_16BIT)
        begin
            case (comp_reg)
                pvdq_pkg::COMP_Y: lane_off_x = offset_y_reg;
                pvdq_pkg::COMP_Z: lane_off_x = offset_z_reg;
                default:          lane_off_x = offset_x_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Lanes
    // ------------------------------------------------------------------
    pvdq_pkg::word_t res_x, res_y, res_z;

    pvdq_lane u_lane_x (
        .clk    (clk),
        .en     (load[LS-1:0]),
        .fmt    (fmt_reg),
        .field  (fld_x),
        .scale  (scale_x_reg),
        .offset (lane_off_x),
        .result (res_x)
    );

    pvdq_lane u_lane_y (
        .clk    (clk),
        .en     (load[LS-1:0]),
        .fmt    (fmt_reg),
        .field  (fld_y),
        .scale  (scale_y_reg),
        .offset (offset_y_reg),
        .result (res_y)
    );

    pvdq_lane u_lane_z (
        .clk    (clk),
        .en     (load[LS-1:0]),
        .fmt    (fmt_reg),
        .field  (fld_z),
        .scale  (scale_z_reg),
        .offset (offset_z_reg),
        .result (res_z)
    );

    // ------------------------------------------------------------------
    // Merge into the output register
    // ------------------------------------------------------------------
    pvdq_pkg::word_t mx, my, mz, mw;

    pvdq_merge u_merge (
        .clk      (clk),
        .en       (load[DEPTH-1]),
        .fmt      (fmt_reg),
        .comp     (comp_reg),
        .lane_x   (res_x),
        .lane_y   (res_y),
        .lane_z   (res_z),
        .offset_x (offset_x_reg),
        .offset_y (offset_y_reg),
        .offset_z (offset_z_reg),
        .out_x    (mx),
        .out_y    (my),
        .out_z    (mz),
        .out_w    (mw)
    );

    assign out_x = signed'(mx);
    assign out_y = signed'(my);
    assign out_z = signed'(mz);
    assign out_w = signed'(mw);

endmodule

`default_nettype wire
